FILE: hdl/cbs_pkg.sv
// Package for the cubic Bezier splitter: payload structs, widths and point codes.
// It depends on nothing. Every other file in this folder but cbs_lerp uses it.
package cbs_pkg;

   // Field widths of the payload, the point count and the lane delay
   localparam int COORD_WIDTH  = 32;
   localparam int T_FRAC_BITS  = 16;
   localparam int T_FIELD_W    = T_FRAC_BITS + 1;
   localparam int NUM_POINTS   = 7;
   localparam int POINT_IDX_W  = 3;
   localparam int LANE_LATENCY = 6;

   // t = 1.0 in Q1.T_FRAC_BITS
   localparam logic [T_FIELD_W-1:0] T_ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

   // Positions in the output sequence
   localparam logic [POINT_IDX_W-1:0] FIRST_INDEX = 3'd0;
   localparam logic [POINT_IDX_W-1:0] NEXT_INDEX  = 3'd1;
   localparam logic [POINT_IDX_W-1:0] LAST_INDEX  = 3'd6;

   // One input item: four control points and the split parameter
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] p0_x;
      logic signed [COORD_WIDTH-1:0] p0_y;
      logic signed [COORD_WIDTH-1:0] p1_x;
      logic signed [COORD_WIDTH-1:0] p1_y;
      logic signed [COORD_WIDTH-1:0] p2_x;
      logic signed [COORD_WIDTH-1:0] p2_y;
      logic signed [COORD_WIDTH-1:0] p3_x;
      logic signed [COORD_WIDTH-1:0] p3_y;
      logic        [T_FIELD_W-1:0]   split_t;
   } req_type;

   // One result item: a single emitted point
   typedef struct packed {
      logic        [POINT_IDX_W-1:0] point_index;
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic                          last;
   } rsp_type;

   // Seven points of one coordinate, as a lane produces them
   typedef logic [NUM_POINTS-1:0][COORD_WIDTH-1:0] lane_points_type;

endpackage

FILE: hdl/cubic_bezier_split.sv
// Cubic Bezier splitter: de Casteljau subdivision at t, with one lane per coordinate.
// Depends on cbs_pkg, cbs_lane (which uses cbs_lerp) and cbs_merge.
//
// Usage:
//   Input: drive req_data and raise start; the transfer happens at a rising edge where
//   start is high and busy is low. split_t above 1.0 is taken as 1.0.
//   Output: seven points P0, AB, ABC, P, BCD, CD, P3 come out on consecutive cycles,
//   each marked by rsp_valid for one cycle, point_index 0 to 6, last on the seventh.
//   The receiver cannot stall; every point must be taken as it appears.
// Timing:
//   A point passes the input register, the lane pipeline and the merge register.
//   busy stays high after a transfer while the hold-off counter runs down, so items
//   are taken no faster than the one-point-per-cycle result port can send them. The
//   x and y lanes are fully pipelined (three interpolation levels of two stages
//   each), so the next item is already being worked while points still go out.
// Reset:
//   Synchronous, active high. It drops busy and any points not yet sent.
module cubic_bezier_split (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  cbs_pkg::req_type req_data,
   output logic             rsp_valid,
   output cbs_pkg::rsp_type rsp_data
);

   localparam int W = cbs_pkg::COORD_WIDTH;
   localparam int F = cbs_pkg::T_FRAC_BITS;

   logic                           accept;
   logic [cbs_pkg::POINT_IDX_W-1:0] hold_ff, hold_in;
   logic                           in_valid_ff;
   logic [cbs_pkg::LANE_LATENCY-1:0] vld_ff;
   logic [3:0][W-1:0]              px_ff, py_ff;
   logic [F:0]                     t_ff, t_sat;
   cbs_pkg::lane_points_type       x_pts, y_pts;
   logic                           lane_load;

   assign accept = start && !busy;
   assign busy   = (hold_ff != '0);

   // hold-off counter between input transfers
   always_comb begin
      hold_in = hold_ff;
      if (accept) begin
         hold_in = cbs_pkg::LAST_INDEX;
      end else if (hold_ff != '0) begin
         hold_in = hold_ff - cbs_pkg::NEXT_INDEX;
      end
   end

   // saturate t to 1.0
   assign t_sat = (req_data.split_t > cbs_pkg::T_ONE) ? cbs_pkg::T_ONE : req_data.split_t;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= '0;
         in_valid_ff <= 1'b0;
         vld_ff      <= '0;
      end else begin
         hold_ff     <= hold_in;
         in_valid_ff <= accept;
         vld_ff      <= {vld_ff[cbs_pkg::LANE_LATENCY-2:0], in_valid_ff};
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= {req_data.p3_x, req_data.p2_x, req_data.p1_x, req_data.p0_x};
         py_ff <= {req_data.p3_y, req_data.p2_y, req_data.p1_y, req_data.p0_y};
         t_ff  <= t_sat;
      end
   end

   // coordinate lanes
   cbs_lane #(.COORD_WIDTH(W), .T_FRAC_BITS(F)) u_lane_x (
      .clock(clock), .p_in(px_ff), .t_in(t_ff), .pt_out(x_pts));
   cbs_lane #(.COORD_WIDTH(W), .T_FRAC_BITS(F)) u_lane_y (
      .clock(clock), .p_in(py_ff), .t_in(t_ff), .pt_out(y_pts));

   assign lane_load = vld_ff[cbs_pkg::LANE_LATENCY-1];

   // merge and send
   cbs_merge u_merge (
      .clock(clock),
      .reset(reset),
      .load(lane_load),
      .x_in(x_pts),
      .y_in(y_pts),
      .rsp_valid(rsp_valid),
      .rsp_data(rsp_data)
   );

   // checks
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("busy not raised after an input transfer");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |=> rsp_valid &&
         rsp_data.point_index == cbs_pkg::POINT_IDX_W'($past(rsp_data.point_index) + 1))
      else $error("point sequence broken");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |-> rsp_data.point_index == cbs_pkg::LAST_INDEX)
      else $error("last set on a point other than the seventh");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      lane_load |-> !rsp_valid || rsp_data.last)
      else $error("lane results arrived while a run was still being sent");

endmodule

FILE: hdl/cbs_lerp.sv
// Two-stage fixed-point linear interpolation: (a*(ONE-t) + b*t + ONE/2) >>> F, wrapped.
// Stand-alone; used by cbs_lane.
module cbs_lerp #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic [COORD_WIDTH-1:0] a_in,
   input  logic [COORD_WIDTH-1:0] b_in,
   input  logic [T_FRAC_BITS:0]   t_in,
   output logic [COORD_WIDTH-1:0] res_out
);

   localparam int PW = COORD_WIDTH + T_FRAC_BITS;

   // half an LSB of the result, in the fraction bits
   localparam logic [T_FRAC_BITS-1:0] HALF = {1'b1, {(T_FRAC_BITS-1){1'b0}}};

   logic signed [COORD_WIDTH:0]   diff;
   logic signed [PW+2:0]          prod;
   logic        [PW-1:0]          prod_ff;
   logic        [COORD_WIDTH-1:0] a_ff;
   logic        [PW-1:0]          sum;
   logic        [COORD_WIDTH-1:0] res_ff;

   // stage 1: (b - a) * t; only the low PW bits matter after wrapping
   assign diff = $signed({b_in[COORD_WIDTH-1], b_in}) - $signed({a_in[COORD_WIDTH-1], a_in});
   assign prod = diff * $signed({1'b0, t_in});

   // stage 2: a*ONE + ONE/2 + product, take the integer part
   assign sum = {a_ff, HALF} + prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod[PW-1:0];
      a_ff    <= a_in;
      res_ff  <= sum[PW-1:T_FRAC_BITS];
   end

   assign res_out = res_ff;

endmodule

FILE: hdl/cbs_lane.sv
// One coordinate lane: three pipelined de Casteljau levels built from cbs_lerp.
// Depends on cbs_pkg (point count) and cbs_lerp.
module cbs_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int T_FRAC_BITS = 16
) (
   input  logic                                          clock,
   input  logic [3:0][COORD_WIDTH-1:0]                   p_in,
   input  logic [T_FRAC_BITS:0]                          t_in,
   output logic [cbs_pkg::NUM_POINTS-1:0][COORD_WIDTH-1:0] pt_out
);

   // delay lines that carry values past the later levels
   logic [COORD_WIDTH-1:0] p0_d_ff  [6];
   logic [COORD_WIDTH-1:0] p3_d_ff  [6];
   logic [COORD_WIDTH-1:0] ab_d_ff  [4];
   logic [COORD_WIDTH-1:0] cd_d_ff  [4];
   logic [COORD_WIDTH-1:0] abc_d_ff [2];
   logic [COORD_WIDTH-1:0] bcd_d_ff [2];
   logic [T_FRAC_BITS:0]   t_d_ff   [4];

   logic [COORD_WIDTH-1:0] ab, bc, cd, abc, bcd, mid;

   // level 1: AB, BC, CD
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_ab (
      .clock(clock), .a_in(p_in[0]), .b_in(p_in[1]), .t_in(t_in), .res_out(ab));
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_bc (
      .clock(clock), .a_in(p_in[1]), .b_in(p_in[2]), .t_in(t_in), .res_out(bc));
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_cd (
      .clock(clock), .a_in(p_in[2]), .b_in(p_in[3]), .t_in(t_in), .res_out(cd));

   // level 2: ABC, BCD
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_abc (
      .clock(clock), .a_in(ab), .b_in(bc), .t_in(t_d_ff[1]), .res_out(abc));
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_bcd (
      .clock(clock), .a_in(bc), .b_in(cd), .t_in(t_d_ff[1]), .res_out(bcd));

   // level 3: the split point
   cbs_lerp #(.COORD_WIDTH(COORD_WIDTH), .T_FRAC_BITS(T_FRAC_BITS)) u_mid (
      .clock(clock), .a_in(abc), .b_in(bcd), .t_in(t_d_ff[3]), .res_out(mid));

   // alignment delays
   always_ff @(posedge clock) begin
      p0_d_ff[0]  <= p_in[0];
      p3_d_ff[0]  <= p_in[3];
      t_d_ff[0]   <= t_in;
      ab_d_ff[0]  <= ab;
      cd_d_ff[0]  <= cd;
      abc_d_ff[0] <= abc;
      bcd_d_ff[0] <= bcd;
      for (int i = 1; i < 6; i++) begin
         p0_d_ff[i] <= p0_d_ff[i-1];
         p3_d_ff[i] <= p3_d_ff[i-1];
      end
      for (int i = 1; i < 4; i++) begin
         t_d_ff[i]  <= t_d_ff[i-1];
         ab_d_ff[i] <= ab_d_ff[i-1];
         cd_d_ff[i] <= cd_d_ff[i-1];
      end
      abc_d_ff[1] <= abc_d_ff[0];
      bcd_d_ff[1] <= bcd_d_ff[0];
   end

   // output order: P0, AB, ABC, P, BCD, CD, P3
   assign pt_out[0] = p0_d_ff[5];
   assign pt_out[1] = ab_d_ff[3];
   assign pt_out[2] = abc_d_ff[1];
   assign pt_out[3] = mid;
   assign pt_out[4] = bcd_d_ff[1];
   assign pt_out[5] = cd_d_ff[3];
   assign pt_out[6] = p3_d_ff[5];

endmodule

FILE: hdl/cbs_merge.sv
// Merge stage: joins the x and y lane results into points and sends them one per cycle.
// Depends on cbs_pkg for the result struct and the point codes.
module cbs_merge (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     load,
   input  cbs_pkg::lane_points_type x_in,
   input  cbs_pkg::lane_points_type y_in,
   output logic                     rsp_valid,
   output cbs_pkg::rsp_type         rsp_data
);

   logic [cbs_pkg::COORD_WIDTH-1:0]  x_buf_ff [cbs_pkg::NUM_POINTS];
   logic [cbs_pkg::COORD_WIDTH-1:0]  y_buf_ff [cbs_pkg::NUM_POINTS];
   logic [cbs_pkg::POINT_IDX_W-1:0]  idx_ff, idx_in;
   logic                             active_ff, active_in;
   logic                             valid_ff, valid_in;
   cbs_pkg::rsp_type                 data_ff, data_in;

   // next point: the first comes straight from the lanes, the rest from the buffer
   always_comb begin
      idx_in    = idx_ff;
      active_in = active_ff;
      valid_in  = 1'b0;
      data_in   = data_ff;
      if (load) begin
         valid_in            = 1'b1;
         active_in           = 1'b1;
         idx_in              = cbs_pkg::NEXT_INDEX;
         data_in.point_index = cbs_pkg::FIRST_INDEX;
         data_in.out_x       = x_in[0];
         data_in.out_y       = y_in[0];
         data_in.last        = 1'b0;
      end else if (active_ff) begin
         valid_in            = 1'b1;
         data_in.point_index = idx_ff;
         data_in.out_x       = x_buf_ff[idx_ff];
         data_in.out_y       = y_buf_ff[idx_ff];
         data_in.last        = (idx_ff == cbs_pkg::LAST_INDEX);
         active_in           = (idx_ff != cbs_pkg::LAST_INDEX);
         idx_in              = idx_ff + cbs_pkg::NEXT_INDEX;
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= cbs_pkg::FIRST_INDEX;
         active_ff <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         active_ff <= active_in;
         valid_ff  <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (load) begin
         for (int i = 0; i < cbs_pkg::NUM_POINTS; i++) begin
            x_buf_ff[i] <= x_in[i];
            y_buf_ff[i] <= y_in[i];
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
